// ===== rtl/mhs_pkg.sv =====
// mhs_pkg: shared types for the sorter and its cells
// no dependencies

package mhs_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // input request payload
  typedef struct packed {
    value_t value;
    logic   last;
  } in_t;

  // result request payload
  typedef struct packed {
    value_t sorted_value;
    logic   final_res;
    logic   overflow;
  } out_t;

  // commands broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   shift;
    value_t value;
  } cell_ctrl_t;

endpackage

// ===== rtl/max_heap_sorter.sv =====
// max_heap_sorter: top level, sorts a set of signed values with a chain of cells
// depends on mhs_pkg and mhs_cell
//
//   channel | ports                         | payload
//   input   | in_valid, in_ready, in_data   | in_t  (value, last)
//   result  | out_valid, out_ready, out_data| out_t (sorted_value, final_res, overflow)
//
// an input request is taken whenever in_ready is high: every cell compares against the value
// and the chain opens a gap at the sorted position in that same cycle
// after the request marked last, the set drains one result per accepted cycle
// from slot 0 until every stored value is out; no input is taken while draining
// rst_n (synchronous, active low) empties the chain and clears the overflow flag
// a stalled result holds the chain still; values past DEPTH are dropped

module max_heap_sorter
  import mhs_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic          dropped_r;

  logic          in_acc;
  logic          out_acc;
  logic          full;
  cell_ctrl_t    ctrl;

  value_t        cell_value [DEPTH];
  logic          cell_gt    [DEPTH];

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_DRAIN);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign full      = (count_r == CW'(DEPTH));

  // broadcast to the chain
  assign ctrl.ins   = in_acc && !full;
  assign ctrl.shift = out_acc;
  assign ctrl.value = in_data.value;

  // result from slot 0
  assign out_data.sorted_value = cell_value[0];
  assign out_data.final_res    = (count_r == CW'(1));
  assign out_data.overflow     = dropped_r;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lv;
    logic   lg;
    value_t rv;
    if (i == 0) begin : g_first
      assign lv = in_data.value;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cell_value[i-1];
      assign lg = cell_gt[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rv = cell_value[i];
    end else begin : g_inner
      assign rv = cell_value[i+1];
    end
    mhs_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_value  (lv),
      .left_gt     (lg),
      .right_value (rv),
      .value       (cell_value[i]),
      .gt          (cell_gt[i])
    );
  end

  // load and drain sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped_r <= 1'b1;
            end else begin
              count_r <= count_r + CW'(1);
            end
            if (in_data.last) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            count_r <= count_r - CW'(1);
            if (count_r == CW'(1)) begin
              state_r   <= ST_LOAD;
              dropped_r <= 1'b0;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // count never goes past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count beyond capacity");

  // a drain never starts on an empty set
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> count_r != '0)
    else $error("drain started with no values");

  // the final result ends the drain
  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.final_res |=> !out_valid && in_ready)
    else $error("drain continued past final result");

  // results come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_data.final_res |=>
      out_valid && (out_data.sorted_value >= $past(out_data.sorted_value)))
    else $error("results out of order");

  // overflow flag is the same on every result of a set
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_data.final_res |=> out_data.overflow == $past(out_data.overflow))
    else $error("overflow flag changed within a set");

endmodule

// ===== rtl/mhs_cell.sv =====
// mhs_cell: one slot of the sorted chain, holds a single value
// depends on mhs_pkg

module mhs_cell
  import mhs_pkg::*;
#(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 6
) (
  input  logic            clk,
  input  cell_ctrl_t      ctrl,
  input  logic [CW-1:0]   count,
  input  value_t          left_value,
  input  logic            left_gt,
  input  value_t          right_value,
  output value_t          value,
  output logic            gt
);

  value_t value_r;
  value_t value_nxt;
  logic   valid;

  // slots at or beyond the count are empty and order as plus infinity
  assign valid = (CW'(IDX) < count);
  assign gt    = !valid || (value_r > ctrl.value);
  assign value = value_r;

  // insert: shift up behind the new value; drain: shift down toward slot 0
  always_comb begin
    value_nxt = value_r;
    if (ctrl.ins) begin
      if (left_gt) begin
        value_nxt = left_value;
      end else if (gt) begin
        value_nxt = ctrl.value;
      end
    end else if (ctrl.shift) begin
      value_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
